// ===== rtl/core/saa_pkg.sv =====
// Shared types and constants for the scatter-add-along-axis block.
`default_nettype none

package saa_pkg;

  localparam int SIZE_W    = 13;  // extent registers
  localparam int COORD_W   = 12;  // update coordinate components
  localparam int IDX_W     = 13;  // signed scatter index
  localparam int ADDR_IN_W = 12;  // flat_address field
  localparam int VAL_W     = 32;  // data_value / read_data fields
  localparam int CFG_IDX_W = 3;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCATTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IDX_ERR  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ADDR_ERR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_OUTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_INNER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPD_OUTER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPD_MIDDLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPD_INNER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS        = 3'd6;

  // control from the sequencer to the coordinate tracker
  typedef struct packed {
    logic restart;  // zero the coordinate before use
    logic step;     // advance after use
  } coord_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/saa_coord.sv =====
// Update coordinate tracker: row-major walk over the update tensor.
`default_nettype none

module saa_coord #(
  parameter int MAX_RANK = 3
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  saa_pkg::coord_ctrl_t                      ctrl_i,
  input  logic [2:0][saa_pkg::SIZE_W-1:0]           upd_size_i,
  output logic [2:0][saa_pkg::COORD_W-1:0]          coord_o
);
  import saa_pkg::*;

  logic [2:0][COORD_W-1:0] coord_q;
  logic [2:0][COORD_W-1:0] coord_d;
  logic [2:0][SIZE_W-1:0]  ext;
  logic [COORD_W:0]        inc;
  logic                    carry;

  // leading dimensions beyond the rank, and a zero extent, behave as 1
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      if (d >= 3 - MAX_RANK && upd_size_i[d] != '0) begin
        ext[d] = upd_size_i[d];
      end else begin
        ext[d] = SIZE_W'(1);
      end
    end
  end

  assign coord_o = ctrl_i.restart ? '0 : coord_q;

  always_comb begin
    carry   = 1'b1;
    inc     = '0;
    coord_d = coord_o;
    for (int d = 2; d >= 0; d--) begin
      inc = {1'b0, coord_o[d]} + (COORD_W+1)'(1);
      if (carry) begin
        if (inc >= ext[d] || inc[COORD_W]) begin
          coord_d[d] = '0;
        end else begin
          coord_d[d] = inc[COORD_W-1:0];
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
    end else if (ctrl_i.step) begin
      coord_q <= coord_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scatter_add_along_axis.sv =====
// Scatter-add along one axis into a tensor store: top level.
//
// The store holds STORE_DEPTH words of DATA_WIDTH bits in one synchronous
// single-port-per-direction memory and starts undefined: load every element
// before it is read or scattered into. One word is worked at a time. A scatter
// add runs the two address multiplies in series (outer coordinate * middle
// extent, then * inner extent), then the range check with the store read,
// then the add and write-back. The result word sits in an output register,
// so the block returns to accepting while it waits. Extent writes reach the
// store-size product through the registered partial and total products, and
// axis writes act directly;
// write them only while the block is idle.
`default_nettype none

module scatter_add_along_axis #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_RANK    = 3,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [saa_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [saa_pkg::SIZE_W-1:0]            cfg_data_i,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [saa_pkg::CMD_W-1:0]             command_i,
  input  logic [saa_pkg::ADDR_IN_W-1:0]         flat_address_i,
  input  logic signed [saa_pkg::IDX_W-1:0]      index_value_i,
  input  logic signed [saa_pkg::VAL_W-1:0]      data_value_i,
  input  logic                                  restart_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [saa_pkg::VAL_W-1:0]      read_data_o,
  output logic [saa_pkg::STATUS_W-1:0]          status_o
);
  import saa_pkg::*;

  localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int EXT_W  = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int P1_W   = 2 * SIZE_W + 1;       // c0*ext1 + c1
  localparam int M2_W   = P1_W + SIZE_W;
  localparam int FLAT_W = M2_W + 1;             // (..)*ext2 + c2
  localparam int PR_W   = 2 * SIZE_W;
  localparam int TOT_W  = 3 * SIZE_W;
  localparam logic [FLAT_W-1:0] DEPTH_L = FLAT_W'(STORE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_CHECK, S_ADD, S_RDATA, S_DONE
  } state_e;

  // configuration registers
  logic [2:0][SIZE_W-1:0] data_size_q;
  logic [2:0][SIZE_W-1:0] upd_size_q;
  logic [1:0]             axis_q;
  logic [PR_W-1:0]        prod01_q;
  logic [TOT_W-1:0]       total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q <= {3{SIZE_W'(1)}};
      upd_size_q  <= {3{SIZE_W'(1)}};
      axis_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DATA_OUTER:  data_size_q[0] <= cfg_data_i;
        CFG_DATA_MIDDLE: data_size_q[1] <= cfg_data_i;
        CFG_DATA_INNER:  data_size_q[2] <= cfg_data_i;
        CFG_UPD_OUTER:   upd_size_q[0]  <= cfg_data_i;
        CFG_UPD_MIDDLE:  upd_size_q[1]  <= cfg_data_i;
        CFG_UPD_INNER:   upd_size_q[2]  <= cfg_data_i;
        CFG_AXIS:        axis_q         <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // effective data extents: dimensions beyond the rank are 1
  logic [2:0][SIZE_W-1:0] dext;
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      dext[d] = (d >= 3 - MAX_RANK) ? data_size_q[d] : SIZE_W'(1);
    end
  end

  // store size product, registered as the outer*middle product and then the total
  always_ff @(posedge clk_i) begin
    prod01_q <= PR_W'(dext[0]) * PR_W'(dext[1]);
    total_q  <= TOT_W'(prod01_q) * TOT_W'(dext[2]);
  end

  // captured input word and work registers
  state_e                    state_q;
  logic [CMD_W-1:0]          cmd_q;
  logic [ADDR_IN_W-1:0]      addr_q;
  logic signed [IDX_W-1:0]   idx_q;
  logic signed [VAL_W-1:0]   data_q;
  logic                      restart_q;
  logic [P1_W-1:0]           p1_q;
  logic [SIZE_W-1:0]         c2_q;
  logic [FLAT_W-1:0]         flat_q;
  logic [VAL_W-1:0]          res_data_q;
  logic [STATUS_W-1:0]       res_status_q;
  logic                      out_valid_q;
  logic [VAL_W-1:0]          read_data_q;
  logic [STATUS_W-1:0]       status_q;

  // coordinate tracker
  coord_ctrl_t             coord_ctrl;
  logic [2:0][COORD_W-1:0] coord;

  assign coord_ctrl.restart = (state_q == S_MUL1) && (cmd_q == CMD_SCATTER) && restart_q;
  assign coord_ctrl.step    = (state_q == S_MUL1) && (cmd_q == CMD_SCATTER);

  saa_coord #(
    .MAX_RANK (MAX_RANK)
  ) u_coord (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (coord_ctrl),
    .upd_size_i (upd_size_q),
    .coord_o    (coord)
  );

  // index check and axis substitution
  logic [1:0]                axis;
  logic [SIZE_W-1:0]         ext_ax;
  logic signed [SIZE_W+1:0]  idx_s;
  logic signed [SIZE_W+1:0]  ext_s;
  logic                      idx_err;
  logic [SIZE_W-1:0]         repl;
  logic [2:0][SIZE_W-1:0]    cf;
  logic [PR_W-1:0]           m1;
  logic [P1_W-1:0]           p1;
  logic [M2_W-1:0]           m2;
  logic [FLAT_W-1:0]         flat;
  logic                      addr_in_range;
  logic                      flat_err;

  always_comb begin
    axis    = (axis_q == 2'd3) ? 2'd2 : axis_q;
    ext_ax  = dext[axis];
    idx_s   = (SIZE_W+2)'(idx_q);
    ext_s   = $signed({2'b00, ext_ax});
    idx_err = (idx_s < -ext_s) || (idx_s >= ext_s);
    // negative index wraps once
    repl    = idx_q[IDX_W-1] ? SIZE_W'(idx_s + ext_s) : SIZE_W'(idx_s);
    for (int d = 0; d < 3; d++) begin
      cf[d] = (d == int'(axis)) ? repl : SIZE_W'(coord[d]);
    end
    m1   = PR_W'(cf[0]) * PR_W'(dext[1]);
    p1   = P1_W'(m1) + P1_W'(cf[1]);
    m2   = M2_W'(p1_q) * M2_W'(dext[2]);
    flat = FLAT_W'(m2) + FLAT_W'(c2_q);
    addr_in_range = FLAT_W'(addr_q) < DEPTH_L;
    flat_err      = (flat_q >= FLAT_W'(total_q)) || (flat_q >= DEPTH_L);
  end

  // tensor store
  logic [DATA_WIDTH-1:0] mem_q [STORE_DEPTH];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic signed [EXT_W-1:0] val_ext;
  logic signed [EXT_W-1:0] rd_ext;
  logic [DATA_WIDTH-1:0] val_w;

  always_comb begin
    val_ext = EXT_W'(data_q);
    val_w   = val_ext[DATA_WIDTH-1:0];
    rd_ext  = EXT_W'($signed(rdata_q));

    mem_we    = 1'b0;
    mem_waddr = AW'(addr_q);
    mem_wdata = val_w;
    mem_re    = 1'b0;
    mem_raddr = AW'(addr_q);
    case (state_q)
      S_MUL1: begin
        mem_we = (cmd_q == CMD_LOAD) && addr_in_range;
        mem_re = (cmd_q == CMD_READ) && addr_in_range;
      end
      S_CHECK: begin
        mem_re    = !flat_err;
        mem_raddr = flat_q[AW-1:0];
      end
      S_ADD: begin
        // one word in flight, so the read above cannot be stale
        mem_we    = 1'b1;
        mem_waddr = flat_q[AW-1:0];
        mem_wdata = rdata_q + val_w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // result register takes a new word when empty or being drained
  logic res_push;
  assign res_push = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      addr_q       <= '0;
      idx_q        <= '0;
      data_q       <= '0;
      restart_q    <= 1'b0;
      p1_q         <= '0;
      c2_q         <= '0;
      flat_q       <= '0;
      res_data_q   <= '0;
      res_status_q <= STAT_OK;
      out_valid_q  <= 1'b0;
      read_data_q  <= '0;
      status_q     <= STAT_OK;
    end else begin
      if (res_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= command_i;
            addr_q    <= flat_address_i;
            idx_q     <= index_value_i;
            data_q    <= data_value_i;
            restart_q <= restart_i;
            state_q   <= S_MUL1;
          end
        end
        S_MUL1: begin
          res_data_q <= '0;
          p1_q       <= p1;
          c2_q       <= cf[2];
          case (cmd_q)
            CMD_LOAD: begin
              res_status_q <= addr_in_range ? STAT_OK : STAT_ADDR_ERR;
              state_q      <= S_DONE;
            end
            CMD_READ: begin
              res_status_q <= addr_in_range ? STAT_OK : STAT_ADDR_ERR;
              state_q      <= addr_in_range ? S_RDATA : S_DONE;
            end
            CMD_SCATTER: begin
              res_status_q <= idx_err ? STAT_IDX_ERR : STAT_OK;
              state_q      <= idx_err ? S_DONE : S_MUL2;
            end
            default: begin
              res_status_q <= STAT_OK;
              state_q      <= S_DONE;
            end
          endcase
        end
        S_MUL2: begin
          flat_q  <= flat;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (flat_err) begin
            res_status_q <= STAT_ADDR_ERR;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          state_q <= S_DONE;
        end
        S_RDATA: begin
          res_data_q <= rd_ext[VAL_W-1:0];
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (res_push) begin
            read_data_q <= res_data_q;
            status_q    <= res_status_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = $signed(read_data_q);
  assign status_o    = status_q;

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MUL1))
    else $error("accepted word did not start work");

  // the add only ever writes inside the configured tensor and the store
  a_add_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> (flat_q < FLAT_W'(total_q) && flat_q < DEPTH_L))
    else $error("scatter write outside the store");

  // a new result comes only from the completion state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result word without completion");

  // store is not written while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

endmodule

`default_nettype wire

// ===== bench/tb_scatter_add_along_axis.sv =====
// Self-checking testbench for scatter_add_along_axis: predicts each result word and compares it.
module tb_scatter_add_along_axis;
  timeunit 1ns;
  timeprecision 1ps;

  import saa_pkg::*;

  localparam int DEPTH      = 4096;
  localparam int COORD_WRAP = 4096;
  localparam int QUIET_MAX  = 2000;
  localparam int PRINT_MAX  = 100;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int AXIS_ALIAS = 3;  // behaves as the innermost axis

  typedef struct {
    logic signed [VAL_W-1:0] read_data;
    logic [STATUS_W-1:0]     status;
  } result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [SIZE_W-1:0]           cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [CMD_W-1:0]            command_i;
  logic [ADDR_IN_W-1:0]        flat_address_i;
  logic signed [IDX_W-1:0]     index_value_i;
  logic signed [VAL_W-1:0]     data_value_i;
  logic                        restart_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [VAL_W-1:0]     read_data_o;
  logic [STATUS_W-1:0]         status_o;

  // predictor state
  logic signed [VAL_W-1:0] tensor_model [DEPTH];
  bit                      loaded [DEPTH];
  int                      loaded_addrs [$];
  int                      coord [3];
  int                      data_ext [3];
  int                      upd_ext [3];
  int                      axis_reg;
  result_t                 pending_results [$];

  int mismatches;
  int quiet_cycles;
  int words_sent;
  bit no_idle;

  scatter_add_along_axis i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .flat_address_i (flat_address_i),
    .index_value_i  (index_value_i),
    .data_value_i   (data_value_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(99) < 9);
  endfunction

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= idle_roll();
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && in_valid_i && !in_stall_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      quiet_cycles = 0;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.read_data)
          report_mismatch($sformatf("read_data %0d, expected %0d", read_data_o, want.read_data));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // --- predictor ---

  // Store position a scatter would hit from the current update coordinate.
  function automatic void locate_target(input logic signed [IDX_W-1:0] idx, input logic rst,
                                        output int flat, output logic [STATUS_W-1:0] st);
    longint c [3];
    longint e, i, f, total;
    int ax;
    ax = (axis_reg > 2) ? 2 : axis_reg;
    for (int d = 0; d < 3; d++) c[d] = rst ? 0 : coord[d];
    e = data_ext[ax];
    i = idx;
    flat = 0;
    st = STAT_OK;
    if (i < -e || i >= e) begin
      st = STAT_IDX_ERR;
    end else begin
      c[ax] = (i < 0) ? i + e : i;
      f = (c[0] * data_ext[1] + c[1]) * data_ext[2] + c[2];
      total = longint'(data_ext[0]) * data_ext[1] * data_ext[2];
      if (f >= total || f >= DEPTH) st = STAT_ADDR_ERR;
      else flat = int'(f);
    end
  endfunction

  // Row-major advance over the update tensor; an extent of zero counts as one.
  function automatic void step_coordinate();
    int n, lim;
    bit carry;
    carry = 1'b1;
    for (int d = 2; d >= 0; d--) begin
      if (carry) begin
        lim = (upd_ext[d] == 0) ? 1 : upd_ext[d];
        n = coord[d] + 1;
        if (n >= lim || n >= COORD_WRAP) begin
          coord[d] = 0;
        end else begin
          coord[d] = n;
          carry = 1'b0;
        end
      end
    end
  endfunction

  function automatic void apply_word(input logic [CMD_W-1:0] cmd,
                                     input logic [ADDR_IN_W-1:0] addr,
                                     input logic signed [IDX_W-1:0] idx,
                                     input logic signed [VAL_W-1:0] val,
                                     input logic rst);
    result_t r;
    int flat;
    r.read_data = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_LOAD: begin
        tensor_model[addr] = val;
        if (!loaded[addr]) begin
          loaded[addr] = 1'b1;
          loaded_addrs.insert(loaded_addrs.size(), int'(addr));
        end
      end
      CMD_READ: r.read_data = tensor_model[addr];
      CMD_SCATTER: begin
        locate_target(idx, rst, flat, r.status);
        if (rst) coord = '{0, 0, 0};
        if (r.status == STAT_OK) tensor_model[flat] = tensor_model[flat] + val;
        step_coordinate();
      end
      default: ;
    endcase
    pending_results.insert(pending_results.size(), r);
  endfunction

  // --- stimulus ---

  // Valid stays high into the next word unless a gap is rolled.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_IN_W-1:0] addr,
                           input logic signed [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val, input logic rst);
    if (idle_roll()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (idle_roll());
    end
    apply_word(cmd, addr, idx, val, rst);
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    flat_address_i <= addr;
    index_value_i  <= idx;
    data_value_i   <= val;
    restart_i      <= rst;
    words_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic load_word(input int addr, input logic signed [VAL_W-1:0] val);
    send_word(CMD_LOAD, ADDR_IN_W'(addr), IDX_W'($urandom), val, 1'($urandom_range(1)));
  endtask

  task automatic read_word();
    int addr;
    if (loaded_addrs.size() == 0) begin
      load_word($urandom_range(DEPTH - 1), $urandom);
    end else begin
      addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
      send_word(CMD_READ, ADDR_IN_W'(addr), IDX_W'($urandom), $urandom,
                1'($urandom_range(1)));
    end
  endtask

  // Loads the target first if it was never written.
  task automatic scatter_word(input logic signed [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val, input logic rst);
    int flat;
    logic [STATUS_W-1:0] st;
    locate_target(idx, rst, flat, st);
    if (st == STAT_OK && !loaded[flat]) load_word(flat, $urandom);
    send_word(CMD_SCATTER, ADDR_IN_W'($urandom_range(DEPTH - 1)), idx, val, rst);
  endtask

  function automatic logic signed [IDX_W-1:0] in_range_index();
    int e;
    e = data_ext[(axis_reg > 2) ? 2 : axis_reg];
    return IDX_W'(int'($urandom_range(2 * e - 1)) - e);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[SIZE_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_DATA_OUTER:  data_ext[0] = value;
      CFG_DATA_MIDDLE: data_ext[1] = value;
      CFG_DATA_INNER:  data_ext[2] = value;
      CFG_UPD_OUTER:   upd_ext[0] = value;
      CFG_UPD_MIDDLE:  upd_ext[1] = value;
      CFG_UPD_INNER:   upd_ext[2] = value;
      CFG_AXIS:        axis_reg = value & 3;
      default: ;
    endcase
  endtask

  task automatic configure(input int d0, input int d1, input int d2,
                           input int u0, input int u1, input int u2, input int ax);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // last scatter may still be writing back
    repeat (8) @(posedge clk_i);
    write_reg(CFG_DATA_OUTER, d0);
    write_reg(CFG_DATA_MIDDLE, d1);
    write_reg(CFG_DATA_INNER, d2);
    write_reg(CFG_UPD_OUTER, u0);
    write_reg(CFG_UPD_MIDDLE, u1);
    write_reg(CFG_UPD_INNER, u2);
    write_reg(CFG_AXIS, ax);
    cfg_we_i <= 1'b0;
    // let the registered size product settle after the write
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly row-major scatter runs opening with restart; the rest is noise.
  task automatic random_phase(input int count);
    int stop, len, r;
    longint ut;
    logic rst;
    stop = words_sent + count;
    while (words_sent < stop) begin
      if ($urandom_range(99) < 75) begin
        ut = 1;
        for (int d = 0; d < 3; d++) ut = ut * ((upd_ext[d] == 0) ? 1 : upd_ext[d]);
        len = $urandom_range(1, (ut < 20) ? int'(2 * ut) : 40);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          rst = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
          if (r < 6) load_word($urandom_range(DEPTH - 1), $urandom);
          else if (r < 12) read_word();
          else if (r < 20) scatter_word(IDX_W'($urandom), $urandom, rst);
          else scatter_word(in_range_index(), $urandom, rst);
        end
      end else begin
        case ($urandom_range(3))
          0: load_word($urandom_range(DEPTH - 1), $urandom);
          1: read_word();
          2: scatter_word(IDX_W'($urandom), $urandom, 1'($urandom_range(1)));
          default: send_word(CMD_UNUSED, ADDR_IN_W'($urandom), IDX_W'($urandom), $urandom,
                             1'($urandom_range(1)));
        endcase
      end
    end
  endtask

  // --- tests ---

  task automatic test_directed_cases();
    configure(1, 2, 3, 1, 3, 4, 2);
    load_word(0, 32'sh7FFF_FFFF);
    load_word(1, 32'sh8000_0000);
    load_word(2, -1);
    load_word(3, 0);
    load_word(4, 1);
    load_word(5, 12345);
    // restart on a load is ignored
    send_word(CMD_LOAD, ADDR_IN_W'(DEPTH - 1), IDX_W'(-1), -1, 1'b1);
    scatter_word(0, 1, 1'b1);                      // positive overflow wraps
    scatter_word(-1, -1, 1'b0);                    // negative index wraps once
    scatter_word(2, 32'sh8000_0000, 1'b0);
    scatter_word(3, 5, 1'b0);                      // index equal to extent
    scatter_word(-4, 5, 1'b0);                     // below minus extent
    scatter_word(-3, 7, 1'b0);
    scatter_word(4095, 1, 1'b0);
    scatter_word(-4096, 1, 1'b0);
    scatter_word(0, 9, 1'b0);                      // middle coordinate past the data extent
    scatter_word(1, 9, 1'b0);
    scatter_word(0, 3, 1'b1);
    send_word(CMD_READ, 0, 0, 0, 1'b1);
    send_word(CMD_READ, 2, 0, 0, 1'b0);
    send_word(CMD_READ, 3, 0, 0, 1'b0);
    send_word(CMD_READ, 5, 0, 0, 1'b0);
    send_word(CMD_READ, ADDR_IN_W'(DEPTH - 1), IDX_W'(-1), -1, 1'b1);
    send_word(CMD_UNUSED, ADDR_IN_W'(DEPTH - 1), IDX_W'(-1), -1, 1'b1);
  endtask

  task automatic test_regular_shapes();
    configure(4, 5, 6, 4, 5, 6, 0);
    random_phase(250);
    configure(8, 8, 8, 3, 9, 10, 1);
    random_phase(250);
    configure(2, 3, 7, 5, 2, 3, AXIS_ALIAS);
    random_phase(250);
  endtask

  task automatic test_back_to_back();
    configure(16, 16, 16, 16, 16, 16, 2);
    no_idle = 1'b1;
    random_phase(250);
    no_idle = 1'b0;
  endtask

  task automatic test_extreme_extents();
    configure(4096, 1, 1, 4096, 1, 1, 0);
    random_phase(150);
    configure(1, 1, 4096, 0, 0, 4096, AXIS_ALIAS);
    random_phase(150);
    configure(4096, 4096, 4096, 4096, 4096, 4096, 1);
    random_phase(150);
    configure(1, 1, 1, 1, 1, 1, 0);
    random_phase(100);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    command_i      <= CMD_LOAD;
    flat_address_i <= '0;
    index_value_i  <= '0;
    data_value_i   <= '0;
    restart_i      <= 1'b0;
    coord          = '{0, 0, 0};
    data_ext       = '{1, 1, 1};
    upd_ext        = '{1, 1, 1};
    axis_reg       = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    words_sent     = 0;
    no_idle        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_regular_shapes();
    test_back_to_back();
    test_extreme_extents();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/saa_pkg.sv
rtl/core/saa_coord.sv
rtl/core/scatter_add_along_axis.sv
bench/tb_scatter_add_along_axis.sv
